@@ src/energy_gate_segmenter_core_defines.svh @@
// Assertion helpers for the energy gate segmenter.
`ifndef ENERGY_GATE_SEGMENTER_CORE_DEFINES_SVH
`define ENERGY_GATE_SEGMENTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EGS_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication.
`define EGS_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

@@ src/egs_pkg.sv @@
package egs_pkg;

   localparam int FRAME_LEN_DEFAULT = 320;

   localparam int ENERGY_W = 41;
   localparam int COUNT_W  = 24;
   localparam int INDEX_W  = 48;
   localparam int SAMPLE_W = 16;
   localparam int SQ_W     = 31;
   localparam int REASON_W = 2;
   localparam int CSR_DW   = 64;
   localparam int CSR_AW   = 6;
   localparam int RSP_DW   = 120;

   typedef enum logic [2:0] {
      REG_START_ENERGY = 3'd0,
      REG_STOP_ENERGY  = 3'd1,
      REG_MIN_SPEECH   = 3'd2,
      REG_HANGOVER     = 3'd3,
      REG_MAX_SEGMENT  = 3'd4,
      REG_PRE_ROLL     = 3'd5
   } reg_index_type;

   typedef enum logic [REASON_W-1:0] {
      REASON_HANGOVER = 2'd0,
      REASON_MAX_LEN  = 2'd1,
      REASON_FLUSH    = 2'd2
   } close_reason_type;

   localparam logic [ENERGY_W-1:0] START_ENERGY_RESET = 41'd34359738;
   localparam logic [ENERGY_W-1:0] STOP_ENERGY_RESET  = 41'd10848000;
   localparam logic [COUNT_W-1:0]  MIN_SPEECH_RESET   = 24'd3200;
   localparam logic [COUNT_W-1:0]  HANGOVER_RESET     = 24'd8000;
   localparam logic [COUNT_W-1:0]  MAX_SEGMENT_RESET  = 24'd480000;
   localparam logic [COUNT_W-1:0]  PRE_ROLL_RESET     = 24'd4800;

   // Saturating add of two sample counts.
   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
   endfunction

endpackage

@@ src/energy_gate_segmenter_core.sv @@
// Energy voice gate. Each sample is squared in the first stage and added to a
// frame sum in the second; every FRAME_LEN samples the finished frame drives
// the open/close decisions and one result transaction leaves the output
// register, and a flush (tuser high) always yields one result. Throughput is
// one input transaction per clock, through the stage-1 and output registers.
// An input stalls only when it would emit a result while the output register
// still holds one that has not been taken. Thresholds are raw per-frame sums
// of squares. Segment start index and length are reported, never the samples.
`include "energy_gate_segmenter_core_defines.svh"

module energy_gate_segmenter_core #(
   parameter int FRAME_LEN = egs_pkg::FRAME_LEN_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // input stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [egs_pkg::SAMPLE_W-1:0] req_tdata,  // [15:0] sample
   input  logic                         req_tuser,  // [0] op: 0 sample, 1 flush
   // result stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [40:0] frame_energy, [41] active, [42] opened, [43] closed,
   // [45:44] close_reason, [93:46] seg_start_index, [117:94] seg_length,
   // [119:118] zero
   output logic [egs_pkg::RSP_DW-1:0]   rsp_tdata,
   // configuration
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [egs_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [egs_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [egs_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int EW    = egs_pkg::ENERGY_W;
   localparam int CW    = egs_pkg::COUNT_W;
   localparam int IW    = egs_pkg::INDEX_W;
   localparam int FILL_W = $clog2(FRAME_LEN);
   localparam logic [CW-1:0]     FRAME_LEN_C  = CW'(FRAME_LEN);
   localparam logic [FILL_W-1:0] FILL_LAST    = FILL_W'(FRAME_LEN - 1);

   // ---------------- configuration registers ----------------
   logic [EW-1:0] start_energy_ff, stop_energy_ff;
   logic [CW-1:0] min_speech_ff, hangover_ff, max_segment_ff, pre_roll_ff;
   logic          csr_write;
   egs_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = egs_pkg::reg_index_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_energy_ff <= egs_pkg::START_ENERGY_RESET;
         stop_energy_ff  <= egs_pkg::STOP_ENERGY_RESET;
         min_speech_ff   <= egs_pkg::MIN_SPEECH_RESET;
         hangover_ff     <= egs_pkg::HANGOVER_RESET;
         max_segment_ff  <= egs_pkg::MAX_SEGMENT_RESET;
         pre_roll_ff     <= egs_pkg::PRE_ROLL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            egs_pkg::REG_START_ENERGY: start_energy_ff <= csr_pwdata[EW-1:0];
            egs_pkg::REG_STOP_ENERGY:  stop_energy_ff  <= csr_pwdata[EW-1:0];
            egs_pkg::REG_MIN_SPEECH:   min_speech_ff   <= csr_pwdata[CW-1:0];
            egs_pkg::REG_HANGOVER:     hangover_ff     <= csr_pwdata[CW-1:0];
            egs_pkg::REG_MAX_SEGMENT:  max_segment_ff  <= csr_pwdata[CW-1:0];
            egs_pkg::REG_PRE_ROLL:     pre_roll_ff     <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         egs_pkg::REG_START_ENERGY: csr_prdata = {{(egs_pkg::CSR_DW-EW){1'b0}}, start_energy_ff};
         egs_pkg::REG_STOP_ENERGY:  csr_prdata = {{(egs_pkg::CSR_DW-EW){1'b0}}, stop_energy_ff};
         egs_pkg::REG_MIN_SPEECH:   csr_prdata = {{(egs_pkg::CSR_DW-CW){1'b0}}, min_speech_ff};
         egs_pkg::REG_HANGOVER:     csr_prdata = {{(egs_pkg::CSR_DW-CW){1'b0}}, hangover_ff};
         egs_pkg::REG_MAX_SEGMENT:  csr_prdata = {{(egs_pkg::CSR_DW-CW){1'b0}}, max_segment_ff};
         egs_pkg::REG_PRE_ROLL:     csr_prdata = {{(egs_pkg::CSR_DW-CW){1'b0}}, pre_roll_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // ---------------- stage 1: square ----------------
   logic                       s1_valid_ff;
   logic                       s1_op_ff;
   logic [egs_pkg::SQ_W-1:0]   s1_sq_ff;
   logic signed [31:0]         sq_full;
   logic                       req_take, s1_emits, s1_go, out_free;

   assign sq_full  = $signed(req_tdata) * $signed(req_tdata);
   assign req_take = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_take) begin
         s1_op_ff <= req_tuser;
         s1_sq_ff <= sq_full[egs_pkg::SQ_W-1:0];
      end
   end

   // ---------------- stage 2: frame state ----------------
   logic [EW-1:0]     energy_sum_ff, energy_sum_in;
   logic [FILL_W-1:0] frame_fill_ff, frame_fill_in;
   logic [IW-1:0]     sample_count_ff, sample_count_in;
   logic              in_segment_ff, in_segment_in;
   logic [CW-1:0]     speech_count_ff, speech_count_in;
   logic [CW-1:0]     quiet_count_ff, quiet_count_in;
   logic [CW-1:0]     preroll_count_ff, preroll_count_in;
   logic [IW-1:0]     segment_start_ff, segment_start_in;
   logic [CW-1:0]     segment_len_ff, segment_len_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]     o_energy_ff, o_energy_in;
   logic              o_active_ff, o_active_in;
   logic              o_opened_ff, o_opened_in;
   logic              o_closed_ff, o_closed_in;
   logic [egs_pkg::REASON_W-1:0] o_reason_ff, o_reason_in;
   logic [IW-1:0]     o_start_ff, o_start_in;
   logic [CW-1:0]     o_len_ff, o_len_in;

   logic          frame_end;
   logic [EW-1:0] e_sum;
   logic [CW-1:0] spc, qc, seg_len_up, pre;
   logic          do_close;

   assign frame_end  = (frame_fill_ff == FILL_LAST);
   assign s1_emits   = s1_op_ff | frame_end;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign s1_go      = s1_valid_ff & (~s1_emits | out_free);
   assign req_tready = ~s1_valid_ff | s1_go;

   assign e_sum      = energy_sum_ff + {{(EW-egs_pkg::SQ_W){1'b0}}, s1_sq_ff};
   assign spc        = egs_pkg::sat_add(speech_count_ff, FRAME_LEN_C);
   assign qc         = egs_pkg::sat_add(quiet_count_ff, FRAME_LEN_C);
   assign seg_len_up = egs_pkg::sat_add(segment_len_ff, FRAME_LEN_C);
   assign pre        = (preroll_count_ff < pre_roll_ff) ? preroll_count_ff : pre_roll_ff;

   always_comb begin
      energy_sum_in    = energy_sum_ff;
      frame_fill_in    = frame_fill_ff;
      sample_count_in  = sample_count_ff;
      in_segment_in    = in_segment_ff;
      speech_count_in  = speech_count_ff;
      quiet_count_in   = quiet_count_ff;
      preroll_count_in = preroll_count_ff;
      segment_start_in = segment_start_ff;
      segment_len_in   = segment_len_ff;
      o_energy_in      = '0;
      o_opened_in      = 1'b0;
      o_closed_in      = 1'b0;
      o_reason_in      = egs_pkg::REASON_HANGOVER;
      o_start_in       = '0;
      o_len_in         = '0;
      do_close         = 1'b0;

      if (s1_op_ff) begin
         // flush: close any open segment including the partial frame
         if (in_segment_ff) begin
            o_start_in  = segment_start_ff;
            o_len_in    = egs_pkg::sat_add(segment_len_ff,
                                           {{(CW-FILL_W){1'b0}}, frame_fill_ff});
            o_closed_in = 1'b1;
            o_reason_in = egs_pkg::REASON_FLUSH;
            do_close    = 1'b1;
         end
         energy_sum_in    = '0;
         frame_fill_in    = '0;
         preroll_count_in = '0;
      end else begin
         sample_count_in = sample_count_ff + IW'(1);
         if (!frame_end) begin
            energy_sum_in = e_sum;
            frame_fill_in = frame_fill_ff + FILL_W'(1);
         end else begin
            energy_sum_in = '0;
            frame_fill_in = '0;
            o_energy_in   = e_sum;
            if (!in_segment_ff) begin
               if (e_sum > start_energy_ff) begin
                  speech_count_in = spc;
                  if (spc >= min_speech_ff) begin
                     in_segment_in    = 1'b1;
                     o_opened_in      = 1'b1;
                     quiet_count_in   = '0;
                     segment_start_in = sample_count_in - IW'(FRAME_LEN)
                                        - {{(IW-CW){1'b0}}, pre};
                     segment_len_in   = egs_pkg::sat_add(pre, FRAME_LEN_C);
                     o_start_in       = segment_start_in;
                     o_len_in         = segment_len_in;
                  end
               end else begin
                  speech_count_in = '0;
               end
               if (!o_opened_in) begin
                  preroll_count_in = egs_pkg::sat_add(preroll_count_ff, FRAME_LEN_C);
               end else begin
                  preroll_count_in = '0;
               end
            end else begin
               segment_len_in = seg_len_up;
               if (e_sum < stop_energy_ff) begin
                  quiet_count_in = qc;
                  if (qc >= hangover_ff) begin
                     o_closed_in = 1'b1;
                     o_reason_in = egs_pkg::REASON_HANGOVER;
                  end
               end else begin
                  quiet_count_in = '0;
               end
               if (!o_closed_in && seg_len_up >= max_segment_ff) begin
                  o_closed_in = 1'b1;
                  o_reason_in = egs_pkg::REASON_MAX_LEN;
               end
               o_start_in = segment_start_ff;
               o_len_in   = seg_len_up;
               do_close   = o_closed_in;
            end
         end
      end

      if (do_close) begin
         in_segment_in   = 1'b0;
         speech_count_in = '0;
         quiet_count_in  = '0;
         segment_len_in  = '0;
      end
      o_active_in = in_segment_in;

      if (s1_go && s1_emits) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_sum_ff    <= '0;
         frame_fill_ff    <= '0;
         sample_count_ff  <= '0;
         in_segment_ff    <= 1'b0;
         speech_count_ff  <= '0;
         quiet_count_ff   <= '0;
         preroll_count_ff <= '0;
         segment_start_ff <= '0;
         segment_len_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            energy_sum_ff    <= energy_sum_in;
            frame_fill_ff    <= frame_fill_in;
            sample_count_ff  <= sample_count_in;
            in_segment_ff    <= in_segment_in;
            speech_count_ff  <= speech_count_in;
            quiet_count_ff   <= quiet_count_in;
            preroll_count_ff <= preroll_count_in;
            segment_start_ff <= segment_start_in;
            segment_len_ff   <= segment_len_in;
         end
      end
      if (s1_go && s1_emits) begin
         o_energy_ff <= o_energy_in;
         o_active_ff <= o_active_in;
         o_opened_ff <= o_opened_in;
         o_closed_ff <= o_closed_in;
         o_reason_ff <= o_reason_in;
         o_start_ff  <= o_start_in;
         o_len_ff    <= o_len_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, o_len_ff, o_start_ff, o_reason_ff, o_closed_ff,
                        o_opened_ff, o_active_ff, o_energy_ff};

   // ---------------- checks ----------------
   `EGS_ASSERT_NOW(a_close_not_active, clock, reset, rsp_valid_ff && o_closed_ff, !o_active_ff && !o_opened_ff, "closed result still reports an open segment")
   `EGS_ASSERT_NOW(a_idle_len_zero, clock, reset, !in_segment_ff, segment_len_ff == '0, "segment length kept while no segment is open")
   `EGS_ASSERT_NEXT(a_open_sets_state, clock, reset, s1_go && s1_emits && o_opened_in, in_segment_ff && rsp_valid_ff && o_active_ff, "opening frame did not open the segment")

endmodule
